### rtl/sial_pkg.sv
// ----------------------------------------------------------------------------
// sial_pkg
// opcodes and shared constants for the signed integer alu
// ----------------------------------------------------------------------------
package sial_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int OP_W           = 4;
    localparam int FIELD_W        = 64;

    localparam logic [OP_W-1:0] OP_MUL = 4'd0;
    localparam logic [OP_W-1:0] OP_DIV = 4'd1;
    localparam logic [OP_W-1:0] OP_MOD = 4'd2;
    localparam logic [OP_W-1:0] OP_SHL = 4'd3;
    localparam logic [OP_W-1:0] OP_SAR = 4'd4;
    localparam logic [OP_W-1:0] OP_ADD = 4'd5;
    localparam logic [OP_W-1:0] OP_SUB = 4'd6;
    localparam logic [OP_W-1:0] OP_OR  = 4'd7;
    localparam logic [OP_W-1:0] OP_XOR = 4'd8;
    localparam logic [OP_W-1:0] OP_AND = 4'd9;
    localparam logic [OP_W-1:0] OP_EQ  = 4'd10;
    localparam logic [OP_W-1:0] OP_NE  = 4'd11;
    localparam logic [OP_W-1:0] OP_LT  = 4'd12;
    localparam logic [OP_W-1:0] OP_LE  = 4'd13;
    localparam logic [OP_W-1:0] OP_GT  = 4'd14;
    localparam logic [OP_W-1:0] OP_GE  = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            quiet;
        logic            zero;
        logic            ln;
        logic            rn;
    } ctrl_t;

    localparam int CTRL_W = $bits(ctrl_t);

endpackage

### rtl/sial_div_stage.sv
// ----------------------------------------------------------------------------
// sial_div_stage
// one registered step of restoring unsigned division, one quotient bit
// ----------------------------------------------------------------------------
module sial_div_stage
    import sial_pkg::*;
#(
    parameter int W     = DATA_WIDTH_DEF,
    parameter int TAG_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  logic [W-1:0]     rem_in,
    input  logic [W-1:0]     quot_in,
    input  logic [W-1:0]     dvd_in,
    input  logic [W-1:0]     dsr_in,
    input  logic [TAG_W-1:0] tag_in,
    output logic             valid_out,
    output logic [W-1:0]     rem_out,
    output logic [W-1:0]     quot_out,
    output logic [W-1:0]     dvd_out,
    output logic [W-1:0]     dsr_out,
    output logic [TAG_W-1:0] tag_out
);

    logic [W:0]   shifted;
    logic         ge;
    logic [W:0]   diff;
    logic [W-1:0] rem_next;

    always_comb
    begin
        shifted  = {rem_in, dvd_in[W-1]};
        diff     = shifted - {1'b0, dsr_in};
        ge       = shifted >= {1'b0, dsr_in};
        rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= rem_next;
            quot_out <= {quot_in[W-2:0], ge};
            dvd_out  <= {dvd_in[W-2:0], 1'b0};
            dsr_out  <= dsr_in;
            tag_out  <= tag_in;
        end
    end

endmodule

### rtl/signed_integer_binop_alu.sv
// ----------------------------------------------------------------------------
// signed_integer_binop_alu
// pipelined signed alu with multiply, divide and modulo
// ----------------------------------------------------------------------------
// One request enters per cycle and one result leaves per cycle while the
// output is taken. The stages are the input register, operand prep and
// partial products, product sum, DATA_WIDTH restoring-divide steps and
// result select. The divide chain sets the latency. When the output is not
// taken the whole pipe holds.
module signed_integer_binop_alu
    import sial_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // left_operand[63:0], right_operand[127:64], suppress_error[128], zero pad
    input  logic [135:0]  s_axis_tdata,
    // req_type[3:0]
    input  logic [3:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // result_value[63:0]
    output logic [63:0]   m_axis_tdata,
    // div_zero_error[0]
    output logic          m_axis_tuser
);

    localparam int W     = DATA_WIDTH;
    localparam int LO    = (W + 1) / 2;
    localparam int TAG_W = CTRL_W + W;

    logic en;

    // input register
    logic                 a_v_reg;
    logic [OP_W-1:0]      a_op_reg;
    logic signed [W-1:0]  a_l_reg;
    logic signed [W-1:0]  a_r_reg;
    logic                 a_q_reg;

    // prep stage
    logic                 b_v_reg;
    ctrl_t                b_ctrl_reg;
    logic [W-1:0]         b_simple_reg;
    logic [2*LO-1:0]      b_pp0_reg;
    logic [W-1:0]         b_pp1_reg;
    logic [W-1:0]         b_pp2_reg;
    logic [W-1:0]         b_ml_reg;
    logic [W-1:0]         b_mr_reg;

    // product sum stage
    logic                 c_v_reg;
    logic [TAG_W-1:0]     c_tag_reg;
    logic [W-1:0]         c_ml_reg;
    logic [W-1:0]         c_mr_reg;

    // divide chain
    logic                 dv   [0:W];
    logic [W-1:0]         drem [0:W];
    logic [W-1:0]         dquo [0:W];
    logic [W-1:0]         ddvd [0:W];
    logic [W-1:0]         ddsr [0:W];
    logic [TAG_W-1:0]     dtag [0:W];

    // output register
    logic                 o_v_reg;
    logic [W-1:0]         o_res_reg;
    logic                 o_err_reg;

    assign en            = !o_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= s_axis_tvalid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            o_v_reg <= dv[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg <= s_axis_tuser;
            a_l_reg  <= s_axis_tdata[W-1:0];
            a_r_reg  <= s_axis_tdata[FIELD_W+W-1:FIELD_W];
            a_q_reg  <= s_axis_tdata[2*FIELD_W];
        end
    end

    // prep: simple ops, magnitudes, partial products
    logic [5:0]   sh_cnt;
    logic         sh_over;
    logic         lt_lr;
    logic         lt_rl;
    logic [W-1:0] simple_next;
    ctrl_t        ctrl_next;

    always_comb
    begin
        sh_cnt  = a_r_reg[5:0];
        sh_over = 32'(sh_cnt) >= W;
        lt_lr   = a_l_reg < a_r_reg;
        lt_rl   = a_r_reg < a_l_reg;
        unique case (a_op_reg)
            OP_SHL:  simple_next = sh_over ? '0 : W'(a_l_reg <<< sh_cnt);
            OP_SAR:  simple_next = sh_over ? {W{a_l_reg[W-1]}} : W'(a_l_reg >>> sh_cnt);
            OP_ADD:  simple_next = W'(a_l_reg + a_r_reg);
            OP_SUB:  simple_next = W'(a_l_reg - a_r_reg);
            OP_OR:   simple_next = a_l_reg | a_r_reg;
            OP_XOR:  simple_next = a_l_reg ^ a_r_reg;
            OP_AND:  simple_next = a_l_reg & a_r_reg;
            OP_EQ:   simple_next = W'(a_l_reg == a_r_reg);
            OP_NE:   simple_next = W'(a_l_reg != a_r_reg);
            OP_LT:   simple_next = W'(lt_lr);
            OP_LE:   simple_next = W'(!lt_rl);
            OP_GT:   simple_next = W'(lt_rl);
            OP_GE:   simple_next = W'(!lt_lr);
            default: simple_next = '0;
        endcase
        ctrl_next.op    = a_op_reg;
        ctrl_next.quiet = a_q_reg;
        ctrl_next.zero  = a_r_reg == '0;
        ctrl_next.ln    = a_l_reg[W-1];
        ctrl_next.rn    = a_r_reg[W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ctrl_reg   <= ctrl_next;
            b_simple_reg <= simple_next;
            b_pp0_reg    <= a_l_reg[LO-1:0] * a_r_reg[LO-1:0];
            b_pp1_reg    <= W'(a_l_reg[LO-1:0] * a_r_reg[W-1:LO]);
            b_pp2_reg    <= W'(a_l_reg[W-1:LO] * a_r_reg[LO-1:0]);
            b_ml_reg     <= a_l_reg[W-1] ? W'(-a_l_reg) : a_l_reg;
            b_mr_reg     <= a_r_reg[W-1] ? W'(-a_r_reg) : a_r_reg;
        end
    end

    // product sum, merged into the side result
    logic [W-1:0] mul_sum;
    logic [W-1:0] cross_sum;

    always_comb
    begin
        cross_sum = W'(b_pp1_reg + b_pp2_reg);
        mul_sum   = W'(W'(b_pp0_reg) + (cross_sum << LO));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_tag_reg <= {b_ctrl_reg,
                          (b_ctrl_reg.op == OP_MUL) ? mul_sum : b_simple_reg};
            c_ml_reg  <= b_ml_reg;
            c_mr_reg  <= b_mr_reg;
        end
    end

    assign dv[0]   = c_v_reg;
    assign drem[0] = '0;
    assign dquo[0] = '0;
    assign ddvd[0] = c_ml_reg;
    assign ddsr[0] = c_mr_reg;
    assign dtag[0] = c_tag_reg;

    for (genvar i = 0; i < W; i++)
    begin : g_div
        sial_div_stage #(
            .W     (W),
            .TAG_W (TAG_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv[i]),
            .rem_in    (drem[i]),
            .quot_in   (dquo[i]),
            .dvd_in    (ddvd[i]),
            .dsr_in    (ddsr[i]),
            .tag_in    (dtag[i]),
            .valid_out (dv[i+1]),
            .rem_out   (drem[i+1]),
            .quot_out  (dquo[i+1]),
            .dvd_out   (ddvd[i+1]),
            .dsr_out   (ddsr[i+1]),
            .tag_out   (dtag[i+1])
        );
    end

    // final select
    ctrl_t        f_ctrl;
    logic [W-1:0] f_side;
    logic [W-1:0] res_next;
    logic         err_next;
    logic         is_div;

    always_comb
    begin
        f_ctrl   = dtag[W][TAG_W-1:W];
        f_side   = dtag[W][W-1:0];
        is_div   = f_ctrl.op == OP_DIV || f_ctrl.op == OP_MOD;
        err_next = is_div && f_ctrl.zero && !f_ctrl.quiet;
        if (is_div && f_ctrl.zero)
        begin
            res_next = '0;
        end
        else if (f_ctrl.op == OP_DIV)
        begin
            res_next = (f_ctrl.ln ^ f_ctrl.rn) ? W'(-dquo[W]) : dquo[W];
        end
        else if (f_ctrl.op == OP_MOD)
        begin
            res_next = f_ctrl.ln ? W'(-drem[W]) : drem[W];
        end
        else
        begin
            res_next = f_side;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_res_reg <= res_next;
            o_err_reg <= err_next;
        end
    end

    logic signed [W-1:0] o_res_s;
    assign o_res_s       = o_res_reg;
    assign m_axis_tvalid = o_v_reg;
    assign m_axis_tdata  = 64'(o_res_s);
    assign m_axis_tuser  = o_err_reg;

    // error only from divide or modulo by zero, with a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && o_err_reg |-> o_res_reg == '0)
        else $error("error flag with nonzero result");

    a_err_src: assert property (@(posedge clk) disable iff (!rst_n)
        en && dv[W] && err_next |=> o_err_reg && o_v_reg)
        else $error("error flag lost at output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_v_reg && !m_axis_tready |=> o_v_reg && $stable(o_res_reg))
        else $error("stalled result changed");

endmodule

### tb/sv/signed_integer_binop_alu_tb.sv
// ----------------------------------------------------------------------------
// signed_integer_binop_alu_tb
// streaming check of the signed alu against an in-bench arithmetic model
// ----------------------------------------------------------------------------
// Directed corners (operand extremes, every opcode, divide by zero with and
// without suppression, most negative over minus one, shift counts) are sent
// first, then random requests mixing extremes with random values. Both sides
// of the stream stall at random, and once the output holds off for a long
// stretch so the pipe fills and backs up. Each result is checked in order.
// ----------------------------------------------------------------------------
module signed_integer_binop_alu_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sial_pkg::*;

    typedef struct {
        logic [63:0] value;
        logic        dz_err;
    } alu_result_t;

    class alu_scoreboard;
        alu_result_t pending[$];
        int          errors = 0;

        function alu_result_t compute(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                                      logic quiet);
            alu_result_t r;
            logic signed [63:0] sa;
            logic signed [63:0] sb;
            sa = a;
            sb = b;
            r.value = '0;
            r.dz_err = 1'b0;
            case (op)
                OP_MUL: r.value = a * b;
                OP_DIV, OP_MOD:
                begin
                    if (b == 0)
                        r.dz_err = ~quiet;
                    else if (a == 64'h8000_0000_0000_0000 && b == '1)
                        r.value = (op == OP_DIV) ? a : '0;
                    else
                        r.value = (op == OP_DIV) ? sa / sb : sa % sb;
                end
                OP_SHL: r.value = a << b[5:0];
                OP_SAR: r.value = sa >>> b[5:0];
                OP_ADD: r.value = a + b;
                OP_SUB: r.value = a - b;
                OP_OR:  r.value = a | b;
                OP_XOR: r.value = a ^ b;
                OP_AND: r.value = a & b;
                OP_EQ:  r.value = {63'd0, a == b};
                OP_NE:  r.value = {63'd0, a != b};
                OP_LT:  r.value = {63'd0, sa < sb};
                OP_LE:  r.value = {63'd0, sa <= sb};
                OP_GT:  r.value = {63'd0, sa > sb};
                default: r.value = {63'd0, sa >= sb};
            endcase
            return r;
        endfunction

        function void note_request(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                                   logic quiet);
            pending.push_back(compute(op, a, b, quiet));
        endfunction

        function void check_result(logic [63:0] value, logic dz_err);
            alu_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result value=%h err=%b", value, dz_err);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (value !== e.value)
            begin
                $error("result_value expected %h actual %h", e.value, value);
                errors++;
            end
            if (dz_err !== e.dz_err)
            begin
                $error("div_zero_error expected %b actual %b", e.dz_err, dz_err);
                errors++;
            end
        endfunction
    endclass

    localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_V = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          RAND_ITEMS = 1000;
    localparam longint      CYCLE_LIMIT = 400000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic [3:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;

    alu_scoreboard sb = new();
    bit            sending_done = 1'b0;
    bit            hold_off_done = 1'b0;
    longint        cycles = 0;

    signed_integer_binop_alu u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_request(logic [3:0] op, logic [63:0] a, logic [63:0] b,
                                logic quiet);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, quiet, b, a};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_request(op, a, b, quiet);
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN_V;
            1: return MAX_V;
            2: return '0;
            3: return '1;
            4: return 64'($urandom_range(0, 70));
            5: return -64'($urandom_range(1, 70));
            6: return {{32{1'b0}}, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    initial
    begin
        logic [63:0] edges[6];
        logic [3:0]  op;
        edges = '{MIN_V, MAX_V, 64'd0, '1, 64'd1, 64'd64};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < 16; k++)
            send_request(4'(k), edges[k % 6], edges[(k + 2) % 6], 1'b0);
        send_request(OP_DIV, MIN_V, '1, 1'b0);
        send_request(OP_MOD, MIN_V, '1, 1'b0);
        send_request(OP_DIV, 64'd7, 64'd0, 1'b0);
        send_request(OP_MOD, 64'd7, 64'd0, 1'b1);
        send_request(OP_DIV, -64'd7, 64'd2, 1'b0);
        send_request(OP_MOD, -64'd7, 64'd2, 1'b0);
        send_request(OP_SAR, MIN_V, 64'd63, 1'b0);
        send_request(OP_SHL, '1, 64'hFFFF_FFFF_FFFF_FF41, 1'b1);
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            op = 4'($urandom_range(0, 15));
            send_request(op, pick_operand(), pick_operand(), 1'($urandom()));
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // output side, with one long hold-off while requests keep coming
    initial
    begin
        int stall;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off_done = 1'b1;
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !hold_off_done && cycles < 300)
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        wait (sending_done && hold_off_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### signed_integer_binop_alu.f
rtl/sial_pkg.sv
rtl/sial_div_stage.sv
rtl/signed_integer_binop_alu.sv
tb/sv/signed_integer_binop_alu_tb.sv
